@@ hw/rtl/scmd_pkg.sv @@
// Shared constants for the serial command motor drive: frame geometry, codes and port widths.
package scmd_pkg;

    // Frame store depth in bytes (valid range 3 to 8).
    localparam int FRAME_BYTES = 8;
    localparam int CNT_W       = $clog2(FRAME_BYTES);

    // Length field of the first frame byte and the width used to compare against it.
    localparam int LEN_W = 3;
    localparam int CMP_W = LEN_W + 1;

    // Stream payload widths.
    localparam int S_TDATA_W = 16;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 24;

    // Configuration port widths.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DUTY     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEAD_TICKS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_OPCODE = 2'd2;

    // Register reset values.
    localparam logic [7:0]  MAX_DUTY_RST     = 8'd100;
    localparam logic [15:0] DEAD_TICKS_RST   = 16'd2;
    localparam logic [7:0]  SPEED_OPCODE_RST = 8'h0A;

    // Input word kinds carried on tuser.
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Direction bit codes.
    localparam logic [3:0] DIR_LEFT_REV  = 4'h1;
    localparam logic [3:0] DIR_LEFT_FWD  = 4'h2;
    localparam logic [3:0] DIR_RIGHT_FWD = 4'h4;
    localparam logic [3:0] DIR_RIGHT_REV = 4'h8;

endpackage

@@ hw/rtl/serial_command_motor_drive.sv @@
// Top level of the serial command motor drive: frame assembly, speed decode and dead time.
//
// The block takes one input word per cycle and returns exactly one result word for each,
// registered in the cycle after acceptance; all decoding is a single pass of short logic from the
// held state into the result register, so back-to-back input words are accepted as long
// as the result register is empty or is being drained in the same cycle. An input word
// is either a received serial byte (tuser low) or a time tick (tuser high). Bytes with a
// framing error are dropped. Other bytes fill a frame whose first byte gives, in its low
// three bits, how many more bytes follow; a frame also closes when the store is full.
// A closed frame whose first byte equals speed_opcode carries signed left and right
// speeds in bytes one and two. Each speed becomes a forward/reverse pair and a magnitude
// clipped to max_duty. When the direction pair changes and dead_ticks is nonzero, both
// duties drop to zero for dead_ticks ticks, after which the new pair and duties take
// effect on the tick that ends the dead time; a frame closing during the dead time
// replaces the pending values without restarting the count. Each result word reports
// the duties, direction bits, a dead time flag and whether this word applied a speed
// frame. Configuration writes take effect at the clock edge where cfg_we is high.
module serial_command_motor_drive (
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration write port.
    input  logic                                cfg_we,
    input  logic [scmd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [scmd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // Input stream.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [scmd_pkg::S_TDATA_W-1:0]      s_tdata,  // rx_byte[7:0], framing_error[8]
    input  logic [scmd_pkg::S_TUSER_W-1:0]      s_tuser,  // opcode[0]
    // Result stream.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // left_duty[7:0], right_duty[15:8], direction_bits[19:16],
    // dead_time_active[20], command_applied[21]
    output logic [scmd_pkg::M_TDATA_W-1:0]      m_tdata
);
    import scmd_pkg::*;

    // Configuration registers.
    logic [7:0]  max_duty_reg;
    logic [15:0] dead_ticks_reg;
    logic [7:0]  speed_opcode_reg;

    // Frame store; entries have no reset, and a short frame can read entries never written.
    logic [7:0] frame_store_reg [FRAME_BYTES];

    // Control and drive state.
    logic [CNT_W-1:0] byte_count_reg,        byte_count_next;
    logic [3:0]       drive_direction_reg,   drive_direction_next;
    logic [7:0]       left_level_reg,        left_level_next;
    logic [7:0]       right_level_reg,       right_level_next;
    logic [3:0]       pending_direction_reg, pending_direction_next;
    logic [7:0]       pending_left_reg,      pending_left_next;
    logic [7:0]       pending_right_reg,     pending_right_next;
    logic [15:0]      dead_counter_reg,      dead_counter_next;

    // Result register.
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg,  m_tdata_next;

    logic       accept;
    logic       in_opcode;
    logic [7:0] in_byte;
    logic       in_ferr;
    logic       byte_ok;
    logic [7:0] fs0, fs1, fs2;
    logic [CNT_W:0] held;
    logic       frame_done;
    logic       speed_frame;
    logic       applied;
    logic       l_neg, r_neg;
    logic [7:0] l_mag, r_mag;
    logic [3:0] new_dir;

    // Two's complement magnitude, then clipped; -128 comes out as 128 before the clip.
    function automatic logic [7:0] clip_mag(input logic [7:0] raw, input logic [7:0] top);
        logic [7:0] mag;
        mag = raw[7] ? (8'd0 - raw) : raw;
        return (mag > top) ? top : mag;
    endfunction

    assign s_tready  = !m_tvalid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign in_opcode = s_tuser[0];
    assign in_byte   = s_tdata[7:0];
    assign in_ferr   = s_tdata[8];
    assign byte_ok   = accept && (in_opcode == OP_BYTE) && !in_ferr;

    // The byte arriving now is forwarded over the store entry it is about to fill.
    assign fs0 = (byte_count_reg == CNT_W'(0)) ? in_byte : frame_store_reg[0];
    assign fs1 = (byte_count_reg == CNT_W'(1)) ? in_byte : frame_store_reg[1];
    assign fs2 = (byte_count_reg == CNT_W'(2)) ? in_byte : frame_store_reg[2];

    assign held       = {1'b0, byte_count_reg} + (CNT_W+1)'(1);
    assign frame_done = (CMP_W'(held) > CMP_W'(fs0[LEN_W-1:0]))
                     || (held >= (CNT_W+1)'(FRAME_BYTES));
    assign speed_frame = frame_done && (fs0 == speed_opcode_reg);
    assign applied     = byte_ok && speed_frame;

    assign l_neg   = fs1[7];
    assign r_neg   = fs2[7];
    assign l_mag   = clip_mag(fs1, max_duty_reg);
    assign r_mag   = clip_mag(fs2, max_duty_reg);
    assign new_dir = (l_neg ? DIR_LEFT_REV : DIR_LEFT_FWD) | (r_neg ? DIR_RIGHT_REV : DIR_RIGHT_FWD);

    always_comb
    begin
        byte_count_next        = byte_count_reg;
        drive_direction_next   = drive_direction_reg;
        left_level_next        = left_level_reg;
        right_level_next       = right_level_reg;
        pending_direction_next = pending_direction_reg;
        pending_left_next      = pending_left_reg;
        pending_right_next     = pending_right_reg;
        dead_counter_next      = dead_counter_reg;

        if (accept && (in_opcode == OP_TICK))
        begin
            if (dead_counter_reg != 16'd0)
            begin
                dead_counter_next = dead_counter_reg - 16'd1;
                // The tick that ends the dead time shows the pending values at once.
                if (dead_counter_reg == 16'd1)
                begin
                    drive_direction_next = pending_direction_reg;
                    left_level_next      = pending_left_reg;
                    right_level_next     = pending_right_reg;
                end
            end
        end
        else if (byte_ok)
        begin
            byte_count_next = frame_done ? CNT_W'(0) : held[CNT_W-1:0];
            if (speed_frame)
            begin
                priority if (dead_counter_reg != 16'd0)
                begin
                    // Replace what waits; the count keeps running.
                    pending_direction_next = new_dir;
                    pending_left_next      = l_mag;
                    pending_right_next     = r_mag;
                end
                else if ((new_dir != drive_direction_reg) && (dead_ticks_reg != 16'd0))
                begin
                    pending_direction_next = new_dir;
                    pending_left_next      = l_mag;
                    pending_right_next     = r_mag;
                    left_level_next        = 8'd0;
                    right_level_next       = 8'd0;
                    dead_counter_next      = dead_ticks_reg;
                end
                else
                begin
                    drive_direction_next = new_dir;
                    left_level_next      = l_mag;
                    right_level_next     = r_mag;
                end
            end
        end
    end

    always_comb
    begin
        m_tdata_next  = m_tdata_reg;
        m_tvalid_next = m_tvalid_reg;
        if (accept)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = M_TDATA_W'({applied, (dead_counter_next != 16'd0),
                                        drive_direction_next, right_level_next,
                                        left_level_next});
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Frame store write: one byte at the current fill position.
    always_ff @(posedge clk)
    begin
        if (byte_ok)
        begin
            frame_store_reg[byte_count_reg] <= in_byte;
        end
    end

    // Result payload needs no reset; it is qualified by m_tvalid.
    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_duty_reg          <= MAX_DUTY_RST;
            dead_ticks_reg        <= DEAD_TICKS_RST;
            speed_opcode_reg      <= SPEED_OPCODE_RST;
            byte_count_reg        <= '0;
            drive_direction_reg   <= '0;
            left_level_reg        <= '0;
            right_level_reg       <= '0;
            pending_direction_reg <= '0;
            pending_left_reg      <= '0;
            pending_right_reg     <= '0;
            dead_counter_reg      <= '0;
            m_tvalid_reg          <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_MAX_DUTY:     max_duty_reg     <= cfg_wdata[7:0];
                    REG_DEAD_TICKS:   dead_ticks_reg   <= cfg_wdata[15:0];
                    REG_SPEED_OPCODE: speed_opcode_reg <= cfg_wdata[7:0];
                    default:          ;
                endcase
            end
            byte_count_reg        <= byte_count_next;
            drive_direction_reg   <= drive_direction_next;
            left_level_reg        <= left_level_next;
            right_level_reg       <= right_level_next;
            pending_direction_reg <= pending_direction_next;
            pending_left_reg      <= pending_left_next;
            pending_right_reg     <= pending_right_next;
            dead_counter_reg      <= dead_counter_next;
            m_tvalid_reg          <= m_tvalid_next;
        end
    end

    // During dead time both duties are held at zero.
    a_dead_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (dead_counter_reg != 16'd0) |-> (left_level_reg == 8'd0 && right_level_reg == 8'd0))
        else $error("duty nonzero during dead time");

    // The fill position never reaches the store depth.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, byte_count_reg} < (CNT_W+1)'(FRAME_BYTES)))
        else $error("byte count out of range");

    // The tick that ends the dead time applies the pending direction.
    a_dead_end: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_opcode == OP_TICK && dead_counter_reg == 16'd1)
        |=> (drive_direction_reg == $past(pending_direction_reg)))
        else $error("pending direction not applied at end of dead time");

    // A dead period starts only from a speed frame.
    a_dead_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(dead_counter_reg != 16'd0) |-> $past(applied))
        else $error("dead time started without a speed frame");

endmodule

@@ bench/serial_command_motor_drive_watch.sv @@
// Result checker for the serial command motor drive: mirrors frame and dead time state and compares words.
module serial_command_motor_drive_watch
    import scmd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // rx_byte[7:0], framing_error[8]
    input  logic [S_TUSER_W-1:0]  s_tuser,   // opcode[0]
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    // left_duty[7:0], right_duty[15:8], direction_bits[19:16],
    // dead_time_active[20], command_applied[21]
    input  logic [M_TDATA_W-1:0]  m_tdata,
    output int                    fail_count,
    output int                    words_waiting
);

    typedef struct {
        logic [7:0] left_duty;
        logic [7:0] right_duty;
        logic [3:0] direction;
        logic       dead_active;
        logic       applied;
    } drive_word_t;

    // Register copies.
    logic [7:0]  duty_limit;
    logic [15:0] dead_len;
    logic [7:0]  speed_code;

    // Frame assembly and drive state.
    logic [7:0]  frame_mem [FRAME_BYTES];
    int          bytes_held;
    logic [3:0]  dir_now;
    logic [3:0]  dir_next;
    logic [7:0]  left_now;
    logic [7:0]  right_now;
    logic [7:0]  left_next;
    logic [7:0]  right_next;
    logic [15:0] dead_left;

    drive_word_t predicted_words [$];
    int          errors;
    int          word_index;

    // Magnitude of a signed speed byte, clipped to the duty limit; -128 gives 128 before clipping.
    function automatic logic [7:0] clip_speed(input logic [7:0] raw);
        logic [8:0] mag;
        mag = raw[7] ? (9'd256 - {1'b0, raw}) : {1'b0, raw};
        if (mag > {1'b0, duty_limit})
            mag = {1'b0, duty_limit};
        return mag[7:0];
    endfunction

    task automatic steer(input logic [7:0] lraw, input logic [7:0] rraw);
        logic [3:0] dir;
        logic [7:0] lmag;
        logic [7:0] rmag;
        lmag = clip_speed(lraw);
        rmag = clip_speed(rraw);
        dir  = (lraw[7] ? DIR_LEFT_REV : DIR_LEFT_FWD) | (rraw[7] ? DIR_RIGHT_REV : DIR_RIGHT_FWD);
        if (dead_left != 16'd0 || (dir != dir_now && dead_len != 16'd0)) begin
            // Park the command; a fresh direction change also starts the dead time.
            dir_next   = dir;
            left_next  = lmag;
            right_next = rmag;
            if (dead_left == 16'd0) begin
                left_now  = 8'd0;
                right_now = 8'd0;
                dead_left = dead_len;
            end
        end
        else begin
            dir_now   = dir;
            left_now  = lmag;
            right_now = rmag;
        end
    endtask

    task automatic step_drive(input logic op, input logic [7:0] rx, input logic fe,
                              output drive_word_t w);
        logic applied;
        applied = 1'b0;
        if (op == OP_TICK) begin
            if (dead_left != 16'd0) begin
                dead_left = dead_left - 16'd1;
                if (dead_left == 16'd0) begin
                    dir_now   = dir_next;
                    left_now  = left_next;
                    right_now = right_next;
                end
            end
        end
        else if (!fe) begin
            frame_mem[bytes_held] = rx;
            bytes_held = bytes_held + 1;
            if (bytes_held > int'(frame_mem[0][LEN_W-1:0]) || bytes_held >= FRAME_BYTES) begin
                bytes_held = 0;
                if (frame_mem[0] == speed_code) begin
                    steer(frame_mem[1], frame_mem[2]);
                    applied = 1'b1;
                end
            end
        end
        w.left_duty   = left_now;
        w.right_duty  = right_now;
        w.direction   = dir_now;
        w.dead_active = (dead_left != 16'd0);
        w.applied     = applied;
    endtask

    task automatic report_mismatch(input string msg);
        if (errors < 40)
            $display("result word %0d: %s", word_index, msg);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n) begin
        drive_word_t want;
        if (!rst_n) begin
            duty_limit = MAX_DUTY_RST;
            dead_len   = DEAD_TICKS_RST;
            speed_code = SPEED_OPCODE_RST;
            for (int i = 0; i < FRAME_BYTES; i++)
                frame_mem[i] = 8'd0;
            bytes_held = 0;
            dir_now    = 4'd0;
            dir_next   = 4'd0;
            left_now   = 8'd0;
            right_now  = 8'd0;
            left_next  = 8'd0;
            right_next = 8'd0;
            dead_left  = 16'd0;
            predicted_words.delete();
            errors     = 0;
            word_index = 0;
            fail_count    <= 0;
            words_waiting <= 0;
        end
        else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_MAX_DUTY:     duty_limit = cfg_wdata[7:0];
                    REG_DEAD_TICKS:   dead_len   = cfg_wdata[15:0];
                    REG_SPEED_OPCODE: speed_code = cfg_wdata[7:0];
                    default: ;
                endcase
            end
            // A result always belongs to an earlier input word, so it is checked first.
            if (m_tvalid && m_tready) begin
                if (predicted_words.size() == 0)
                    report_mismatch($sformatf("arrived with nothing expected (%h)", m_tdata));
                else begin
                    want = predicted_words.pop_front();
                    if (m_tdata[7:0] !== want.left_duty)
                        report_mismatch($sformatf("left duty %h, expected %h",
                                                  m_tdata[7:0], want.left_duty));
                    if (m_tdata[15:8] !== want.right_duty)
                        report_mismatch($sformatf("right duty %h, expected %h",
                                                  m_tdata[15:8], want.right_duty));
                    if (m_tdata[19:16] !== want.direction)
                        report_mismatch($sformatf("direction bits %h, expected %h",
                                                  m_tdata[19:16], want.direction));
                    if (m_tdata[20] !== want.dead_active)
                        report_mismatch($sformatf("dead time flag %b, expected %b",
                                                  m_tdata[20], want.dead_active));
                    if (m_tdata[21] !== want.applied)
                        report_mismatch($sformatf("command applied %b, expected %b",
                                                  m_tdata[21], want.applied));
                end
                word_index++;
            end
            if (s_tvalid && s_tready) begin
                step_drive(s_tuser[0], s_tdata[7:0], s_tdata[8], want);
                predicted_words.push_back(want);
            end
            fail_count    <= errors;
            words_waiting <= predicted_words.size();
        end
    end

endmodule

@@ bench/serial_command_motor_drive_tb.sv @@
// Testbench top for the serial command motor drive: stimulus, handshake pacing and verdict.
module serial_command_motor_drive_tb;
    import scmd_pkg::*;

    // Longest stretch without any word moving before the run is declared hung.
    localparam int HANG_LIMIT = 2000;
    // Index past the last register; a write there must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;   // rx_byte[7:0], framing_error[8]
    logic [S_TUSER_W-1:0]  s_tuser   = '0;   // opcode[0]
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    // left_duty[7:0], right_duty[15:8], direction_bits[19:16],
    // dead_time_active[20], command_applied[21]
    logic [M_TDATA_W-1:0]  m_tdata;

    int fail_count;
    int words_waiting;

    // Pacing controls: idle_on turns random gaps on and off in stretches,
    // quiet_tail removes all gaps for the closing part of the run.
    bit idle_on    = 1'b1;
    bit quiet_tail = 1'b0;
    int stall_left = 0;
    int quiet_cycles = 0;

    // Where the block stands inside a frame, so speed frames can be sent aligned.
    int         frame_pos = 0;
    int         frame_len = 0;
    logic [7:0] cur_op    = SPEED_OPCODE_RST;

    // Counts for the closing summary.
    int words_sent     = 0;
    int ticks_sent     = 0;
    int speed_frames   = 0;
    int settings_used  = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    serial_command_motor_drive u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    serial_command_motor_drive_watch u_watch (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .fail_count    (fail_count),
        .words_waiting (words_waiting)
    );

    // Result side back-pressure: random stalls while idling is on and the quiet tail has not begun.
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            m_tready <= 1'b0;
        end
        else if (idle_on && !quiet_tail && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(0, 5);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // Watchdog: any accepted word or register write restarts the count.
    always @(posedge clk)
    begin
        if (!rst_n || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= HANG_LIMIT)
        begin
            $display("no word moved for %0d cycles", HANG_LIMIT);
            $display("serial_command_motor_drive_tb NOT OK");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Drives one input word and returns at the edge where it is taken. Valid stays high
    // afterwards so that back-to-back words need no extra assignment; an optional idle
    // burst ahead of the word lowers it first.
    task automatic send_word(input logic op, input logic [7:0] rx, input logic fe);
        int gap;
        if (idle_on && !quiet_tail && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 6);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {7'd0, fe, rx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        words_sent++;
        if (op == OP_TICK)
            ticks_sent++;
        else if (!fe)
        begin
            // A good byte either opens a frame, whose low bits give the remaining
            // length, or extends the one in progress.
            if (frame_pos == 0)
                frame_len = rx[LEN_W-1:0];
            frame_pos++;
            if (frame_pos > frame_len)
                frame_pos = 0;
        end
    endtask

    // Speed values lean toward the corners: zero, both ends, -1 and -127.
    function automatic logic [7:0] pick_speed();
        case ($urandom_range(0, 7))
            0: return 8'h80;
            1: return 8'h7F;
            2: return 8'h00;
            3: return 8'hFF;
            4: return 8'h81;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Sends a well-formed speed frame for the present opcode, first closing any frame that
    // noise left open. Ticks and dropped bytes are sprinkled between the frame bytes; they
    // must not disturb assembly.
    task automatic send_speed_frame(input logic [7:0] lspd, input logic [7:0] rspd);
        int         extra;
        logic [7:0] b;
        while (frame_pos != 0)
            send_word(OP_BYTE, 8'($urandom_range(0, 255)), 1'b0);
        send_word(OP_BYTE, cur_op, 1'b0);
        extra = cur_op[LEN_W-1:0];
        for (int k = 1; k <= extra; k++)
        begin
            if ($urandom_range(0, 9) == 0)
                send_word(OP_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            if ($urandom_range(0, 14) == 0)
                send_word(OP_BYTE, 8'($urandom_range(0, 255)), 1'b1);
            b = (k == 1) ? lspd : (k == 2) ? rspd : 8'($urandom_range(0, 255));
            send_word(OP_BYTE, b, 1'b0);
        end
        speed_frames++;
    endtask

    // Lowers valid and waits until every result has been taken.
    task automatic settle_drive();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (words_waiting != 0);
    endtask

    // Writes all three registers with the block idle; optionally also the unused index.
    task automatic program_drive(input logic [7:0] duty, input logic [15:0] ticks,
                                 input logic [7:0] code, input bit poke_spare);
        settle_drive();
        cfg_we    <= 1'b1;
        cfg_index <= REG_MAX_DUTY;
        cfg_wdata <= {8'd0, duty};
        @(posedge clk);
        cfg_index <= REG_DEAD_TICKS;
        cfg_wdata <= ticks;
        @(posedge clk);
        cfg_index <= REG_SPEED_OPCODE;
        cfg_wdata <= {8'd0, code};
        @(posedge clk);
        if (poke_spare)
        begin
            cfg_index <= REG_SPARE;
            cfg_wdata <= 16'($urandom_range(0, 65535));
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        cur_op = code;
        settings_used++;
    endtask

    // Random traffic: mostly aligned speed frames with random content, plus tick bursts,
    // stray bytes, dropped bytes and speed frames abandoned after their first data byte.
    task automatic run_mix(input int count);
        int target;
        int pick;
        target = words_sent + count;
        while (words_sent < target)
        begin
            if ($urandom_range(0, 29) == 0)
                idle_on = !idle_on;
            pick = $urandom_range(0, 99);
            if (pick < 55)
                send_speed_frame(pick_speed(), pick_speed());
            else if (pick < 75)
                repeat ($urandom_range(1, 4))
                    send_word(OP_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            else if (pick < 85)
                send_word(OP_BYTE, 8'($urandom_range(0, 255)), 1'b0);
            else if (pick < 92)
                send_word(OP_BYTE, 8'($urandom_range(0, 255)), 1'b1);
            else
            begin
                while (frame_pos != 0)
                    send_word(OP_BYTE, 8'($urandom_range(0, 255)), 1'b0);
                send_word(OP_BYTE, cur_op, 1'b0);
                send_word(OP_BYTE, pick_speed(), 1'b0);
            end
        end
    endtask

    initial
    begin
        static logic [7:0] fill [8] = '{8'h07, 8'hFF, 8'h00, 8'h80, 8'h7F, 8'h55, 8'hAA, 8'h01};

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under the reset settings. The first frame fills the whole store,
        // so no later short speed frame can read a byte that was never written.
        foreach (fill[i])
            send_word(OP_BYTE, fill[i], 1'b0);
        // A tick with the byte fields set must ignore them; a byte with a framing
        // error must change nothing, even when it looks like the speed opcode.
        send_word(OP_TICK, 8'hFF, 1'b1);
        send_word(OP_BYTE, SPEED_OPCODE_RST, 1'b1);
        // Full forward left, most negative right: both clip, and the direction change
        // starts the dead time.
        send_word(OP_BYTE, SPEED_OPCODE_RST, 1'b0);
        send_word(OP_BYTE, 8'h7F, 1'b0);
        send_word(OP_BYTE, 8'h80, 1'b0);
        // A frame during the dead time replaces the pending command.
        send_word(OP_BYTE, SPEED_OPCODE_RST, 1'b0);
        send_word(OP_BYTE, 8'h05, 1'b0);
        send_word(OP_BYTE, 8'h81, 1'b0);
        // The second tick ends the dead time and shows the pending values at once.
        send_word(OP_TICK, 8'h00, 1'b0);
        send_word(OP_TICK, 8'h00, 1'b0);
        // Same directions: duties change immediately.
        send_word(OP_BYTE, SPEED_OPCODE_RST, 1'b0);
        send_word(OP_BYTE, 8'h10, 1'b0);
        send_word(OP_BYTE, 8'hF0, 1'b0);
        // A one-byte frame with another opcode is ignored.
        send_word(OP_BYTE, 8'h08, 1'b0);

        // Largest duty limit, no dead time, and an opcode whose frame is the opcode byte
        // alone, so the speeds come from stale store bytes.
        program_drive(8'd255, 16'd0, 8'h00, 1'b1);
        send_word(OP_BYTE, 8'h00, 1'b0);
        send_word(OP_BYTE, 8'h00, 1'b0);
        run_mix(130);

        // Smallest duty limit and a one-tick dead time.
        program_drive(8'd1, 16'd1, SPEED_OPCODE_RST, 1'b0);
        run_mix(150);

        // Eight-byte frames that close exactly when the store is full.
        program_drive(8'd255, 16'd3, 8'hFF, 1'b0);
        run_mix(150);

        // Two-byte frames: the right speed byte is stale.
        program_drive(MAX_DUTY_RST, DEAD_TICKS_RST, 8'h81, 1'b0);
        run_mix(130);

        // A long dead time that needs the upper counter bits. The two frames below force a
        // direction change one way or the other, more frames then replace the pending
        // command, and a full count of ticks runs the dead time out.
        program_drive(8'd50, 16'd256, SPEED_OPCODE_RST, 1'b0);
        send_speed_frame(8'h20, 8'h20);
        send_speed_frame(8'hE0, 8'hE0);
        repeat (3)
            send_speed_frame(pick_speed(), pick_speed());
        repeat (260)
            send_word(OP_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));

        repeat (3)
        begin
            program_drive(8'($urandom_range(1, 255)), 16'($urandom_range(0, 6)),
                          8'($urandom_range(0, 255)), 1'b0);
            run_mix(100);
        end

        // Closing part at full rate on both sides.
        program_drive(8'($urandom_range(1, 255)), 16'($urandom_range(0, 6)),
                      SPEED_OPCODE_RST, 1'b0);
        quiet_tail = 1'b1;
        run_mix(130);

        // Drain, then give a stray late word a chance to show up.
        settle_drive();
        repeat (8) @(posedge clk);

        $display("Run covered %0d input words (%0d ticks, %0d speed frames) over %0d settings.",
                 words_sent, ticks_sent, speed_frames, settings_used + 1);
        $display("Duty limits 1 to 255, dead times 0 to 256 ticks, frames of 1 to 8 bytes.");
        if (fail_count == 0 && words_waiting == 0)
            $display("serial_command_motor_drive_tb OK");
        else
        begin
            $display("%0d mismatches, %0d results never arrived", fail_count, words_waiting);
            $display("serial_command_motor_drive_tb NOT OK");
        end
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/scmd_pkg.sv
hw/rtl/serial_command_motor_drive.sv
bench/serial_command_motor_drive_watch.sv
bench/serial_command_motor_drive_tb.sv
